>>> design/bdhs_pkg.sv
// Shared constants, request record and sequencer states for the brush span generator.
package bdhs_pkg;

    localparam int MAX_RADIUS = 31;
    localparam int RAD_W      = 5;
    localparam int MAX_CANVAS = 4096;
    localparam int CANVAS_W   = 13;
    localparam int COORD_W    = 14;
    localparam int POS_W      = 15;
    localparam int OUT_W      = 12;
    localparam int LIM_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEX_GRID      = 2'd2;

    localparam logic [CANVAS_W-1:0] CANVAS_RESET = 13'd256;
    localparam logic [CANVAS_W-1:0] CANVAS_LIMIT = 13'd4096;

    // One queued brush request: centre, clamped radius and r*r + r
    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [RAD_W-1:0]          r;
        logic [LIM_W-1:0]          lim;
    } bdhs_req_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SWEEP,
        BK_FINISH
    } bk_state_t;

endpackage

>>> design/bdhs_front.sv
// Front end: accepts brush requests, clamps the radius and queues them in a two-entry FIFO.
module bdhs_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [bdhs_pkg::COORD_W-1:0] centre_col,
    input  logic signed [bdhs_pkg::COORD_W-1:0] centre_row,
    input  logic signed [5:0]                   brush_radius,
    output logic                                q_valid,
    output bdhs_pkg::bdhs_req_t                 q_data,
    input  logic                                q_pop
);
    import bdhs_pkg::*;

    bdhs_req_t        fifo_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;
    logic [RAD_W-1:0] r_clamp;
    bdhs_req_t        new_req;

    // radius clamp: negative to zero, large values saturate at MAX_RADIUS
    assign r_clamp = brush_radius[5] ? '0 :
                     (brush_radius > 6'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) :
                     brush_radius[RAD_W-1:0];

    always_comb
    begin
        new_req.cx  = centre_col;
        new_req.cy  = centre_row;
        new_req.r   = r_clamp;
        new_req.lim = {5'b0, r_clamp} * {5'b0, r_clamp} + {5'b0, r_clamp};
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && (cnt_reg != 2'd0);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = fifo_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_req;
        end
    end

endmodule

>>> design/bdhs_back.sv
// Back end: sweeps the rows of one request, tracks the disc half width in round mode and emits clipped spans.
module bdhs_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    input  bdhs_pkg::bdhs_req_t                  q_data,
    output logic                                 q_pop,
    input  logic [bdhs_pkg::CANVAS_W-1:0]        canvas_w,
    input  logic [bdhs_pkg::CANVAS_W-1:0]        canvas_h,
    input  logic                                 hex_mode,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [bdhs_pkg::OUT_W-1:0]           span_first_col,
    output logic [bdhs_pkg::OUT_W-1:0]           span_last_col,
    output logic [bdhs_pkg::OUT_W-1:0]           span_row,
    output logic                                 no_span,
    output logic                                 last_span
);
    import bdhs_pkg::*;

    bk_state_t          state_reg, state_next;
    bdhs_req_t          req_reg, req_next;
    logic signed [5:0]  dy_reg, dy_next;
    logic [5:0]         h_reg, h_next;
    logic               held_valid_reg, held_valid_next;
    logic [OUT_W-1:0]   held_first_reg, held_first_next;
    logic [OUT_W-1:0]   held_last_reg, held_last_next;
    logic [OUT_W-1:0]   held_row_reg, held_row_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_first_reg, out_first_next;
    logic [OUT_W-1:0]   out_last_reg, out_last_next;
    logic [OUT_W-1:0]   out_row_reg, out_row_next;
    logic               out_none_reg, out_none_next;
    logic               out_fin_reg, out_fin_next;

    logic signed [6:0]  r_s, dy_s, lo, hi;
    logic [RAD_W-1:0]   dy_abs;
    logic [LIM_W-1:0]   dy_sq;
    logic [5:0]         h_p1, h_p2, h_m1;
    logic [11:0]        sum_h0, sum_p1, sum_p2, sum_m1, lim12;
    logic [5:0]         h_row, h_step;
    logic               row_done;
    logic signed [POS_W-1:0] x0, x1, x0c, x1c, y, w_s, hgt_s;
    logic               survive, need_emit, emit_ok, at_last_row;

    assign r_s    = signed'({2'b00, req_reg.r});
    assign dy_s   = 7'(dy_reg);
    assign dy_abs = dy_reg[5] ? RAD_W'(-dy_reg) : dy_reg[RAD_W-1:0];
    assign dy_sq  = {5'b0, dy_abs} * {5'b0, dy_abs};
    assign lim12  = {2'b00, req_reg.lim};

    // candidate half widths and their squared distances
    assign h_p1   = h_reg + 6'd1;
    assign h_p2   = h_reg + 6'd2;
    assign h_m1   = h_reg - 6'd1;
    assign sum_h0 = {6'b0, h_reg} * {6'b0, h_reg} + {2'b00, dy_sq};
    assign sum_p1 = {6'b0, h_p1} * {6'b0, h_p1} + {2'b00, dy_sq};
    assign sum_p2 = {6'b0, h_p2} * {6'b0, h_p2} + {2'b00, dy_sq};
    assign sum_m1 = {6'b0, h_m1} * {6'b0, h_m1} + {2'b00, dy_sq};

    // half width walk: grows over the upper half, shrinks below centre, two steps a cycle
    always_comb
    begin
        h_row    = h_reg;
        h_step   = h_reg;
        row_done = 1'b1;
        if (!hex_mode)
        begin
            if (!dy_reg[5] && (dy_reg != 6'sd0))
            begin
                priority if (!((h_reg != 6'd0) && (sum_h0 > lim12)))
                    h_row = h_reg;
                else if (!((h_reg > 6'd1) && (sum_m1 > lim12)))
                    h_row = h_m1;
                else
                begin
                    h_step   = h_reg - 6'd2;
                    row_done = 1'b0;
                end
            end
            else
            begin
                priority if (!(sum_p1 <= lim12))
                    h_row = h_reg;
                else if (!(sum_p2 <= lim12))
                    h_row = h_p1;
                else
                begin
                    h_step   = h_p2;
                    row_done = 1'b0;
                end
            end
        end
    end

    // column extent of the row, relative to the centre
    always_comb
    begin
        if (hex_mode)
        begin
            lo = dy_reg[5] ? (-r_s - dy_s) : -r_s;
            hi = (!dy_reg[5] && (dy_reg != 6'sd0)) ? (r_s - dy_s) : r_s;
        end
        else
        begin
            lo = -signed'({1'b0, h_row});
            hi = signed'({1'b0, h_row});
        end
    end

    // clipping against the canvas
    always_comb
    begin
        w_s   = signed'({2'b00, canvas_w});
        hgt_s = signed'({2'b00, canvas_h});
        x0    = POS_W'(req_reg.cx) + POS_W'(lo);
        x1    = POS_W'(req_reg.cx) + POS_W'(hi);
        y     = POS_W'(req_reg.cy) + POS_W'(dy_reg);
        x0c   = x0[POS_W-1] ? '0 : x0;
        x1c   = (x1 >= w_s) ? (w_s - POS_W'(1)) : x1;
        survive = !y[POS_W-1] && (y < hgt_s) && (x0c <= x1c);
    end

    assign emit_ok     = !out_valid_reg || !out_stall;
    assign need_emit   = row_done && survive && held_valid_reg;
    assign at_last_row = (dy_s == r_s);

    // sequencer: next state, span hold stage and output register
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        dy_next         = dy_reg;
        h_next          = h_reg;
        held_valid_next = held_valid_reg;
        held_first_next = held_first_reg;
        held_last_next  = held_last_reg;
        held_row_next   = held_row_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_first_next  = out_first_reg;
        out_last_next   = out_last_reg;
        out_row_next    = out_row_reg;
        out_none_next   = out_none_reg;
        out_fin_next    = out_fin_reg;
        q_pop           = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop           = 1'b1;
                    req_next        = q_data;
                    dy_next         = -signed'({1'b0, q_data.r});
                    h_next          = 6'd0;
                    held_valid_next = 1'b0;
                    state_next      = BK_SWEEP;
                end
            end
            BK_SWEEP:
            begin
                if (!need_emit || emit_ok)
                begin
                    if (row_done)
                    begin
                        h_next = h_row;
                        if (need_emit)
                        begin
                            out_valid_next = 1'b1;
                            out_first_next = held_first_reg;
                            out_last_next  = held_last_reg;
                            out_row_next   = held_row_reg;
                            out_none_next  = 1'b0;
                            out_fin_next   = 1'b0;
                        end
                        if (survive)
                        begin
                            held_valid_next = 1'b1;
                            held_first_next = x0c[OUT_W-1:0];
                            held_last_next  = x1c[OUT_W-1:0];
                            held_row_next   = y[OUT_W-1:0];
                        end
                        if (at_last_row)
                            state_next = BK_FINISH;
                        else
                            dy_next = dy_reg + 6'sd1;
                    end
                    else
                    begin
                        h_next = h_step;
                    end
                end
            end
            BK_FINISH:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_fin_next   = 1'b1;
                    if (held_valid_reg)
                    begin
                        out_first_next = held_first_reg;
                        out_last_next  = held_last_reg;
                        out_row_next   = held_row_reg;
                        out_none_next  = 1'b0;
                    end
                    else
                    begin
                        out_first_next = '0;
                        out_last_next  = '0;
                        out_row_next   = '0;
                        out_none_next  = 1'b1;
                    end
                    held_valid_next = 1'b0;
                    state_next      = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        dy_reg         <= dy_next;
        h_reg          <= h_next;
        held_first_reg <= held_first_next;
        held_last_reg  <= held_last_next;
        held_row_reg   <= held_row_next;
        out_first_reg  <= out_first_next;
        out_last_reg   <= out_last_next;
        out_row_reg    <= out_row_next;
        out_none_reg   <= out_none_next;
        out_fin_reg    <= out_fin_next;
    end

    assign out_valid      = out_valid_reg;
    assign span_first_col = out_first_reg;
    assign span_last_col  = out_last_reg;
    assign span_row       = out_row_reg;
    assign no_span        = out_none_reg;
    assign last_span      = out_fin_reg;

endmodule

>>> design/brush_disc_hex_span_generator.sv
// A request is written into the queue, then loaded into the sequencer's request register.
// A span waits in the hold stage until a later row survives or the sweep ends, then moves
// to the output register; out_stall can delay this. The sequencer sweeps rows -r to +r of
// one request at a time, walking the half width in round mode, then pops the next request.
// A two-entry request queue lets new requests in while a sweep runs.
// Reset (rst_n, async low): queue and sequencer empty, canvas 256 x 256, round brush.
module brush_disc_hex_span_generator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [bdhs_pkg::COORD_W-1:0]   centre_col,
    input  logic signed [bdhs_pkg::COORD_W-1:0]   centre_row,
    input  logic signed [5:0]                     brush_radius,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [bdhs_pkg::OUT_W-1:0]            span_first_col,
    output logic [bdhs_pkg::OUT_W-1:0]            span_last_col,
    output logic [bdhs_pkg::OUT_W-1:0]            span_row,
    output logic                                  no_span,
    output logic                                  last_span,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bdhs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bdhs_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import bdhs_pkg::*;

    logic [CANVAS_W-1:0] canvas_width_reg;
    logic [CANVAS_W-1:0] canvas_height_reg;
    logic                hex_grid_reg;
    logic [CANVAS_W-1:0] canvas_w, canvas_h;
    logic                q_valid, q_pop;
    bdhs_req_t           q_data;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= CANVAS_RESET;
            canvas_height_reg <= CANVAS_RESET;
            hex_grid_reg      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data;
                REG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data;
                REG_HEX_GRID:      hex_grid_reg      <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // canvas size saturates at the largest supported canvas
    assign canvas_w = (canvas_width_reg > CANVAS_LIMIT) ? CANVAS_LIMIT : canvas_width_reg;
    assign canvas_h = (canvas_height_reg > CANVAS_LIMIT) ? CANVAS_LIMIT : canvas_height_reg;

    bdhs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .centre_col   (centre_col),
        .centre_row   (centre_row),
        .brush_radius (brush_radius),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop)
    );

    bdhs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .canvas_w       (canvas_w),
        .canvas_h       (canvas_h),
        .hex_mode       (hex_grid_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .span_first_col (span_first_col),
        .span_last_col  (span_last_col),
        .span_row       (span_row),
        .no_span        (no_span),
        .last_span      (last_span)
    );

endmodule
